FILE: src/gb3_pkg.sv
// Shared constants, types and register codes for the 3x3 binomial blur.
// No dependencies; imported by every module of the block.
package gb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 3;

  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int LS_DATA_W  = 2 * PIX_W;
  // kernel weights add to 16: 16 * 255 fits in 12 bits
  localparam int SUM_W      = PIX_W + 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Per-word position info carried alongside the pixel
  typedef struct packed {
    logic             has_result;
    logic             last;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } meta_t;

endpackage

FILE: src/gb3_ctrl.sv
// Frame geometry registers and raster column/row counters.
// Depends on gb3_pkg; drives the line store address and per-word position info.
module gb3_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gb3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gb3_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            acc,
  output logic [gb3_pkg::COL_W-1:0]       col,
  output gb3_pkg::meta_t                  meta
);
  import gb3_pkg::*;

  localparam logic [FW_W-1:0] W_MIN   = FW_W'(MIN_DIM);
  localparam logic [FW_W-1:0] W_MAX   = FW_W'(MAX_WIDTH);
  localparam logic [FW_W-1:0] W_RESET = FW_W'(640);
  localparam logic [FH_W-1:0] H_MIN   = FH_W'(MIN_DIM);
  localparam logic [FH_W-1:0] H_MAX   = FH_W'(MAX_HEIGHT);
  localparam logic [FH_W-1:0] H_RESET = FH_W'(480);

  logic [FW_W-1:0]  fw_r, fw_nxt;
  logic [FH_W-1:0]  fh_r, fh_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [FW_W-1:0]  w_eff;
  logic [FH_W-1:0]  h_eff;
  logic             col_end;
  logic             row_end;
  logic             cfg_hit;

  always_comb begin
    if (fw_r < W_MIN) begin
      w_eff = W_MIN;
    end else if (fw_r > W_MAX) begin
      w_eff = W_MAX;
    end else begin
      w_eff = fw_r;
    end
    if (fh_r < H_MIN) begin
      h_eff = H_MIN;
    end else if (fh_r > H_MAX) begin
      h_eff = H_MAX;
    end else begin
      h_eff = fh_r;
    end
  end

  assign col_end = ({1'b0, col_r} + FW_W'(1)) >= w_eff;
  assign row_end = ({1'b0, row_r} + FH_W'(1)) >= h_eff;

  assign col             = col_r;
  assign meta.has_result = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
  assign meta.last       = row_end && col_end;
  assign meta.row        = row_r - ROW_W'(1);
  assign meta.col        = col_r - COL_W'(1);

  always_comb begin
    fw_nxt  = fw_r;
    fh_nxt  = fh_r;
    cfg_hit = 1'b0;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH: begin
          fw_nxt  = cfg_wdata[FW_W-1:0];
          cfg_hit = 1'b1;
        end
        REG_FRAME_HEIGHT: begin
          fh_nxt  = cfg_wdata[FH_W-1:0];
          cfg_hit = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // A geometry write restarts the frame; stale line data is never used since
  // a result needs two full rows of the current frame above it.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_hit) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (acc) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= W_RESET;
      fh_r  <= H_RESET;
      col_r <= '0;
      row_r <= '0;
    end else begin
      fw_r  <= fw_nxt;
      fh_r  <= fh_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

FILE: src/gb3_line_store.sv
// Line store: one entry per column holding {upper row, middle row} pixels.
// Depends on gb3_pkg; one write port and one read port with registered data.
module gb3_line_store (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [gb3_pkg::COL_W-1:0]      rd_addr,
  output logic [gb3_pkg::LS_DATA_W-1:0]  rd_data,
  input  logic                           wr_en,
  input  logic [gb3_pkg::COL_W-1:0]      wr_addr,
  input  logic [gb3_pkg::LS_DATA_W-1:0]  wr_data
);
  import gb3_pkg::*;

  logic [LS_DATA_W-1:0] mem_r [MAX_WIDTH];
  logic [LS_DATA_W-1:0] rd_data_r;

  // read data holds while no read is issued, so a stalled word keeps it
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/gb3_window.sv
// Read-modify-write stage, 3x3 window, kernel sum and output register.
// Depends on gb3_pkg; consumes line store read data and writes entries back.
module gb3_window (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           acc,
  input  logic [gb3_pkg::PIX_W-1:0]      acc_pixel,
  input  logic [gb3_pkg::COL_W-1:0]      acc_addr,
  input  gb3_pkg::meta_t                 acc_meta,
  output logic                           s1_ready,
  input  logic [gb3_pkg::LS_DATA_W-1:0]  rd_data,
  output logic                           wr_en,
  output logic [gb3_pkg::COL_W-1:0]      wr_addr,
  output logic [gb3_pkg::LS_DATA_W-1:0]  wr_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gb3_pkg::PIX_W-1:0]      out_filtered,
  output logic [gb3_pkg::ROW_W-1:0]      out_center_row,
  output logic [gb3_pkg::COL_W-1:0]      out_center_col,
  output logic                           out_frame_last
);
  import gb3_pkg::*;

  logic             s1_valid_r, s1_valid_nxt;
  logic [PIX_W-1:0] s1_pix_r;
  logic [COL_W-1:0] s1_addr_r;
  meta_t            s1_meta_r;
  logic             s1_adv;
  logic             out_free;

  // window taps: index 0 top, 1 middle, 2 bottom; old = column 0, new = column 1
  logic [PIX_W-1:0] win_old_r [3];
  logic [PIX_W-1:0] win_new_r [3];
  logic [PIX_W-1:0] col_in    [3];
  logic [SUM_W-1:0] sum_c;

  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_filt_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic             out_last_r;

  assign out_free = !out_valid_r || out_ready;
  // words without a result pass even while the output register is full
  assign s1_adv   = s1_valid_r && (!s1_meta_r.has_result || out_free);
  assign s1_ready = !s1_valid_r || s1_adv;

  assign col_in[0] = rd_data[LS_DATA_W-1:PIX_W];
  assign col_in[1] = rd_data[PIX_W-1:0];
  assign col_in[2] = s1_pix_r;

  // shift the column down: middle moves up, new pixel becomes middle
  assign wr_en   = s1_adv;
  assign wr_addr = s1_addr_r;
  assign wr_data = {col_in[1], s1_pix_r};

  always_comb begin
    sum_c = SUM_W'(win_old_r[0])        + (SUM_W'(win_new_r[0]) << 1) + SUM_W'(col_in[0])
          + (SUM_W'(win_old_r[1]) << 1) + (SUM_W'(win_new_r[1]) << 2)
          + (SUM_W'(col_in[1]) << 1)
          + SUM_W'(win_old_r[2])        + (SUM_W'(win_new_r[2]) << 1) + SUM_W'(col_in[2]);
  end

  assign s1_valid_nxt  = acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = (s1_adv && s1_meta_r.has_result) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pix_r  <= acc_pixel;
      s1_addr_r <= acc_addr;
      s1_meta_r <= acc_meta;
    end
    if (s1_adv) begin
      for (int k = 0; k < 3; k++) begin
        win_old_r[k] <= win_new_r[k];
        win_new_r[k] <= col_in[k];
      end
    end
    if (s1_adv && s1_meta_r.has_result) begin
      // divide by 16; weights add to 16 so the quotient never exceeds 255
      out_filt_r <= sum_c[SUM_W-1:4];
      out_row_r  <= s1_meta_r.row;
      out_col_r  <= s1_meta_r.col;
      out_last_r <= s1_meta_r.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_filtered   = out_filt_r;
  assign out_center_row = out_row_r;
  assign out_center_col = out_col_r;
  assign out_frame_last = out_last_r;

endmodule

FILE: src/gaussian_blur_3x3_core.sv
// 3x3 binomial blur core: accepts one pixel word per cycle unless the output stalls.
// A result enters the output register after the pixel below-right of its center
// is accepted: the line store is read at the accepting edge, then the window sum
// goes into the output register. Throughput is one word per cycle unless the output
// stalls, set by the single line store, read and written once per word.
// Reset: counters clear, geometry returns to 640x480; line stores are not cleared.
module gaussian_blur_3x3_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gb3_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [gb3_pkg::PIX_W-1:0]      in_pixel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [gb3_pkg::PIX_W-1:0]      out_filtered,
  output logic [gb3_pkg::ROW_W-1:0]      out_center_row,
  output logic [gb3_pkg::COL_W-1:0]      out_center_col,
  output logic                           out_frame_last
);
  import gb3_pkg::*;

  logic                 acc;
  logic [COL_W-1:0]     col;
  meta_t                meta;
  logic [LS_DATA_W-1:0] rd_data;
  logic                 wr_en;
  logic [COL_W-1:0]     wr_addr;
  logic [LS_DATA_W-1:0] wr_data;

  assign acc = in_valid && in_ready;

  gb3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .col       (col),
    .meta      (meta)
  );

  gb3_line_store u_line_store (
    .clk     (clk),
    .rd_en   (acc),
    .rd_addr (col),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  gb3_window u_window (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (acc),
    .acc_pixel      (in_pixel),
    .acc_addr       (col),
    .acc_meta       (meta),
    .s1_ready       (in_ready),
    .rd_data        (rd_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_filtered   (out_filtered),
    .out_center_row (out_center_row),
    .out_center_col (out_center_col),
    .out_frame_last (out_frame_last)
  );

endmodule

FILE: src/gb3_checker.sv
// Port-level checks for the blur core, bound to gaussian_blur_3x3_core.
// Depends on gb3_pkg for field widths.
module gb3_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [gb3_pkg::PIX_W-1:0] out_filtered,
  input logic [gb3_pkg::ROW_W-1:0] out_center_row,
  input logic [gb3_pkg::COL_W-1:0] out_center_col,
  input logic                      out_frame_last
);
  import gb3_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered)
      && $stable(out_center_row) && $stable(out_center_col) && $stable(out_frame_last))
    else $error("stalled output word changed");

  a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_center_row != '0 && out_center_col != '0)
    else $error("result word on a border pixel");

  a_interior_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_center_row <= ROW_W'(MAX_HEIGHT - 2)
      && out_center_col <= COL_W'(MAX_WIDTH - 2))
    else $error("result word outside the interior range");

endmodule

bind gaussian_blur_3x3_core gb3_checker u_gb3_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_filtered   (out_filtered),
  .out_center_row (out_center_row),
  .out_center_col (out_center_col),
  .out_frame_last (out_frame_last)
);
